FILE: src/pal_pkg.sv
// Package for the positional array list.
// Holds the operation and status codes, the controller states and the cell control type.
// Depends on nothing.
`default_nettype none

package pal_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_APPEND = 3'd1,
    CM_INSERT = 3'd2,
    CM_REMOVE = 3'd3,
    CM_ROTATE = 3'd4
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e  mode;
    logic [31:0] val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/positional_array_list.sv
// Positional array list: a chain of entry cells and the controller that steers them.
// Clear, append and insert are answered without leaving idle; search, read and delete
// rotate the chain once past its head cell, and delete then closes with a shift.
// A rejected read or delete is answered without leaving idle.
// The result strobe done_o rises for one cycle after the request finishes and the
// receiver cannot stall it; busy_o is high during a rotation or the closing shift.
// Depends on pal_pkg and pal_cell.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         kind_i,
  input  wire logic [4:0]         position_i,
  input  wire logic signed [31:0] value_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      data_out_o,
  output logic                    found_o,
  output logic [4:0]              match_count_o,
  output logic [4:0]              length_o
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = ((CntW > 5) ? CntW : 5) + 1;
  localparam logic [IdxW-1:0] LastStep = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] Full     = CntW'(CAPACITY);

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  op_e                  op_q, op_d;
  logic [IdxW-1:0]      tgt_q, tgt_d;
  logic signed [31:0]   key_q, key_d;
  logic [IdxW-1:0]      step_q, step_d;
  logic [CntW-1:0]      acc_q, acc_d;
  logic signed [31:0]   cap_q, cap_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic signed [31:0]   data_q, data_d;
  logic                 found_q, found_d;
  logic [4:0]           match_q, match_d;
  logic [4:0]           length_q, length_d;

  cell_ctrl_t           ctrl;
  logic [IdxW-1:0]      cell_tgt;
  logic signed [31:0]   entry_w [CAPACITY];
  logic [CmpW-1:0]      pos_ext, cnt_ext;
  logic [IdxW-1:0]      pos_idx;
  logic signed [31:0]   head;

  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign pos_idx = IdxW'(pos_ext - CmpW'(1));
  assign head    = entry_w[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pal_cell #(
      .IdxW  (IdxW),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .tgt_i   (cell_tgt),
      .lower_i (entry_w[(i == 0) ? 0 : i - 1]),
      .upper_i (entry_w[(i + 1) % CAPACITY]),
      .entry_o (entry_w[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    op_d      = op_q;
    tgt_d     = tgt_q;
    key_d     = key_q;
    step_d    = step_q;
    acc_d     = acc_q;
    cap_d     = cap_q;
    done_d    = 1'b0;
    status_d  = status_q;
    data_d    = data_q;
    found_d   = found_q;
    match_d   = match_q;
    length_d  = length_q;
    ctrl.mode = CM_HOLD;
    ctrl.val  = value_i;
    cell_tgt  = tgt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = STAT_OK;
          data_d   = '0;
          found_d  = 1'b0;
          match_d  = '0;
          unique case (kind_i)
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            OP_APPEND: begin
              done_d = 1'b1;
              if (count_q == Full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.mode = CM_APPEND;
                cell_tgt  = IdxW'(count_q);
                count_d   = count_q + CntW'(1);
              end
            end
            OP_INSERT: begin
              done_d = 1'b1;
              if (count_q == Full) begin
                status_d = STAT_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
                status_d = STAT_RANGE;
              end else begin
                ctrl.mode = CM_INSERT;
                cell_tgt  = pos_idx;
                count_d   = count_q + CntW'(1);
              end
            end
            OP_DELETE, OP_READ: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_d = STAT_RANGE;
                done_d   = 1'b1;
              end else begin
                op_d    = op_e'(kind_i);
                tgt_d   = pos_idx;
                step_d  = '0;
                acc_d   = '0;
                state_d = S_SWEEP;
              end
            end
            OP_SEARCH: begin
              op_d    = OP_SEARCH;
              key_d   = value_i;
              step_d  = '0;
              acc_d   = '0;
              state_d = S_SWEEP;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SWEEP: begin
        ctrl.mode = CM_ROTATE;
        if (CntW'(step_q) < count_q && head == key_q) acc_d = acc_q + CntW'(1);
        if (step_q == tgt_q) cap_d = head;
        if (step_q == LastStep) begin
          if (op_q == OP_DELETE) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
            if (op_q == OP_SEARCH) begin
              found_d = (acc_d != '0);
              match_d = (CmpW'(acc_d) > CmpW'(31)) ? 5'd31 : 5'(acc_d);
            end else begin
              data_d = cap_d;
            end
          end
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      S_SHIFT: begin
        ctrl.mode = CM_REMOVE;
        count_d   = count_q - CntW'(1);
        data_d    = cap_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (done_d) begin
      length_d = (CmpW'(count_d) > CmpW'(31)) ? 5'd31 : 5'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tgt_q    <= tgt_d;
    key_q    <= key_d;
    step_q   <= step_d;
    acc_q    <= acc_d;
    cap_q    <= cap_d;
    status_q <= status_d;
    data_q   <= data_d;
    found_q  <= found_d;
    match_q  <= match_d;
    length_q <= length_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_out_o    = data_q;
  assign found_o       = found_q;
  assign match_count_o = match_q;
  assign length_o      = length_q;

endmodule

`default_nettype wire

FILE: src/pal_cell.sv
// One storage cell of the positional array list chain.
// Holds a single entry and takes its next value from the request or a neighbour.
// Depends on pal_pkg.
`default_nettype none

module pal_cell
  import pal_pkg::*;
#(
  parameter int IdxW  = 4,
  parameter int Index = 0
) (
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [IdxW-1:0]   tgt_i,
  input  wire logic signed [31:0] lower_i,
  input  wire logic signed [31:0] upper_i,
  output logic signed [31:0]     entry_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic signed [31:0] entry_q;
  logic signed [31:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.mode)
      CM_APPEND: begin
        if (MyIdx == tgt_i) entry_d = ctrl_i.val;
      end
      CM_INSERT: begin
        if (MyIdx == tgt_i) begin
          entry_d = ctrl_i.val;
        end else if (MyIdx > tgt_i) begin
          entry_d = lower_i;
        end
      end
      CM_REMOVE: begin
        if (MyIdx >= tgt_i) entry_d = upper_i;
      end
      CM_ROTATE: entry_d = upper_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: src/pal_checker.sv
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg and positional_array_list.
`default_nettype none

module pal_checker
  import pal_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic [2:0]         kind_i,
  input wire logic [4:0]         position_i,
  input wire logic signed [31:0] value_i,
  input wire logic               done_o,
  input wire logic [1:0]         status_o,
  input wire logic signed [31:0] data_out_o,
  input wire logic               found_o,
  input wire logic [4:0]         match_count_o,
  input wire logic [4:0]         length_o
);

  // A clear request is answered in the next cycle with an empty list.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i == OP_CLEAR |=> done_o && length_o == 5'd0 &&
    status_o == STAT_OK)
    else $error("clear did not empty the list");

  // A rejected request returns no data.
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STAT_OK |-> data_out_o == '0 && !found_o)
    else $error("rejected request returned data");

  // The found flag agrees with the match count.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> found_o == (match_count_o != 5'd0))
    else $error("found flag and match count disagree");

  // The block only becomes busy after a request has been taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

`default_nettype wire
